@@ rtl/edge_gap_varint_encoder_macros.svh @@
`ifndef EDGE_GAP_VARINT_ENCODER_MACROS_SVH
`define EDGE_GAP_VARINT_ENCODER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define EGV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its condition, outside reset.
`define EGV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/egv_pkg.sv @@
`timescale 1ns / 1ps
package egv_pkg;

    localparam int ID_W       = 32;
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = 5;
    localparam int CNT_W      = 3;
    localparam int FIRST_BITS = 6;
    localparam int GROUP_BITS = 7;

    localparam logic CMD_FIRST = 1'b0;
    localparam logic CMD_PLAIN = 1'b1;

    localparam logic [BYTE_W-1:0] MAG6_MASK  = 8'h3f;
    localparam logic [BYTE_W-1:0] SIGN_BIT   = 8'h40;
    localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;

    // Item after the difference stage.
    typedef struct packed {
        logic            cmd;
        logic            neg;
        logic [ID_W-1:0] mag;
        logic [ID_W-1:0] base;
    } t_mag;

    // Item with its bytes formed, lowest byte first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 cnt;
        logic [ID_W-1:0]                  base;
    } t_grp;

endpackage

@@ rtl/egv_group.sv @@
`timescale 1ns / 1ps
`include "edge_gap_varint_encoder_macros.svh"
module egv_group (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  egv_pkg::t_mag i_mag,
    output logic          o_ready,
    output logic          o_valid,
    output egv_pkg::t_grp o_grp,
    input  logic          i_ready
);
    import egv_pkg::*;

    localparam int VX_W = GROUP_BITS * MAX_BYTES;

    logic                               r_valid;
    t_grp                               r_grp;
    t_grp                               n_grp;
    logic [ID_W-1:0]                    v;
    logic [VX_W-1:0]                    vx;
    logic [CNT_W-1:0]                   ng;
    logic [MAX_BYTES-1:0][BYTE_W-1:0]   grp;

    always_comb begin
        // A first-edge item carries six magnitude bits in its leading byte.
        v  = (i_mag.cmd == CMD_FIRST) ? (i_mag.mag >> FIRST_BITS) : i_mag.mag;
        vx = VX_W'(v);
        priority if (v == '0)
            ng = CNT_W'(0);
        else if (v[ID_W-1:GROUP_BITS] == '0)
            ng = CNT_W'(1);
        else if (v[ID_W-1:2*GROUP_BITS] == '0)
            ng = CNT_W'(2);
        else if (v[ID_W-1:3*GROUP_BITS] == '0)
            ng = CNT_W'(3);
        else if (v[ID_W-1:4*GROUP_BITS] == '0)
            ng = CNT_W'(4);
        else
            ng = CNT_W'(5);

        for (int i = 0; i < MAX_BYTES; i++) begin
            grp[i] = (BYTE_W'(vx[i*GROUP_BITS +: GROUP_BITS]) & GROUP_MASK)
                   | ((ng > CNT_W'(i + 1)) ? CONT_BIT : '0);
        end

        n_grp.base = i_mag.base;
        if (i_mag.cmd == CMD_FIRST) begin
            n_grp.bytes[0] = (i_mag.mag[BYTE_W-1:0] & MAG6_MASK)
                           | (i_mag.neg ? SIGN_BIT : '0)
                           | ((ng != '0) ? CONT_BIT : '0);
            for (int k = 1; k < MAX_BYTES; k++) begin
                n_grp.bytes[k] = grp[k-1];
            end
            n_grp.cnt = ng + CNT_W'(1);
        end else begin
            n_grp.bytes = grp;
            n_grp.cnt   = ng;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_grp   = r_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            // An item that codes to no bytes is dropped here.
            r_valid <= i_valid && (n_grp.cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_grp <= n_grp;
        end
    end

    `EGV_ASSERT(a_grp_cnt_range, !r_valid || (r_grp.cnt != '0 && r_grp.cnt <= CNT_W'(MAX_BYTES)), "byte count out of range")
    `EGV_ASSERT_NEXT(a_grp_hold, r_valid && !i_ready, r_valid && $stable(r_grp), "stalled item changed")

endmodule

@@ rtl/egv_serial.sv @@
`timescale 1ns / 1ps
`include "edge_gap_varint_encoder_macros.svh"
module egv_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  egv_pkg::t_grp              i_grp,
    output logic                       o_ready,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [39:0]                o_m_axis_tdata,  // code_byte, byte_offset
    output logic                       o_m_axis_tlast
);
    import egv_pkg::*;

    logic                             r_s3_valid;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] r_bytes;
    logic [CNT_W-1:0]                 r_rem;
    logic [ID_W-1:0]                  r_off;
    logic                             r_out_valid;
    logic [BYTE_W-1:0]                r_out_byte;
    logic [ID_W-1:0]                  r_out_off;
    logic                             r_out_last;
    logic                             out_free;
    logic                             emit;
    logic                             s3_done;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign emit     = r_s3_valid && out_free;
    assign s3_done  = emit && (r_rem == CNT_W'(1));
    assign o_ready  = !r_s3_valid || s3_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s3_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // The bytes shift down as they leave, so the next one is always at index zero.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes <= i_grp.bytes;
            r_rem   <= i_grp.cnt;
            r_off   <= i_grp.base;
        end else if (emit) begin
            r_bytes <= {BYTE_W'(0), r_bytes[MAX_BYTES-1:1]};
            r_rem   <= r_rem - CNT_W'(1);
            r_off   <= r_off + ID_W'(1);
        end
        if (emit) begin
            r_out_byte <= r_bytes[0];
            r_out_off  <= r_off;
            r_out_last <= (r_rem == CNT_W'(1));
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_off, r_out_byte};
    assign o_m_axis_tlast  = r_out_last;

    `EGV_ASSERT(a_ser_rem, !r_s3_valid || (r_rem != '0 && r_rem <= CNT_W'(MAX_BYTES)), "remaining count out of range")
    `EGV_ASSERT(a_ser_cont, !r_out_valid || (r_out_byte[BYTE_W-1] == !r_out_last), "continuation bit disagrees with last")
    `EGV_ASSERT_NEXT(a_ser_follow, r_out_valid && i_m_axis_tready && !r_out_last, r_out_valid, "item cut short after a non-final byte")

endmodule

@@ rtl/edge_gap_varint_encoder.sv @@
`timescale 1ns / 1ps
// Variable-length byte coder for graph adjacency gaps. An item either codes the signed
// difference target minus source (tuser low) or a plain unsigned gap (tuser high) and
// leaves as one to five bytes, each with its offset (base offset plus index, wrapping)
// and tlast on the final byte; a zero plain gap produces no bytes. The pipeline has a
// difference stage, a byte-forming stage, a serialiser and an output register, and an
// item passes through them in that order. The serialiser sends one byte per cycle while
// the output is not stalled, and it takes the next item as it sends the last byte of
// the current one; an item that codes to nothing costs no output slot.
module edge_gap_varint_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // source_id, target_id, gap, base_offset
    input  logic          i_s_axis_tuser,   // cmd
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [39:0]   o_m_axis_tdata,   // code_byte, byte_offset
    output logic          o_m_axis_tlast
);
    import egv_pkg::*;

    logic            r_s1_valid;
    t_mag            r_s1;
    t_mag            n_s1;
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] tgt;
    logic [ID_W-1:0] d_fwd;
    logic [ID_W-1:0] d_rev;
    logic            grp_ready;
    logic            grp_valid;
    t_grp            grp;
    logic            ser_ready;

    assign src   = i_s_axis_tdata[31:0];
    assign tgt   = i_s_axis_tdata[63:32];
    assign d_fwd = tgt - src;
    assign d_rev = src - tgt;

    always_comb begin
        n_s1.cmd  = i_s_axis_tuser;
        n_s1.base = i_s_axis_tdata[127:96];
        if (i_s_axis_tuser == CMD_FIRST) begin
            n_s1.neg = (tgt < src);
            n_s1.mag = n_s1.neg ? d_rev : d_fwd;
        end else begin
            n_s1.neg = 1'b0;
            n_s1.mag = i_s_axis_tdata[95:64];
        end
    end

    assign o_s_axis_tready = !r_s1_valid || grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_s1 <= n_s1;
        end
    end

    egv_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_mag   (r_s1),
        .o_ready (grp_ready),
        .o_valid (grp_valid),
        .o_grp   (grp),
        .i_ready (ser_ready)
    );

    egv_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (grp_valid),
        .i_grp           (grp),
        .o_ready         (ser_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

@@ bench/edge_gap_varint_encoder_check.sv @@
`timescale 1ns / 1ps
module edge_gap_varint_encoder_check
    import egv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // source_id, target_id, gap, base_offset
    input  logic         i_s_axis_tuser,   // cmd
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [39:0]  i_m_axis_tdata,   // code_byte, byte_offset
    input  logic         i_m_axis_tlast,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic [ID_W-1:0]   offset;
        logic              last;
    } t_coded_byte;

    t_coded_byte expected_bytes[$];
    int          mismatch_count;

    initial begin
        mismatch_count = 0;
        o_fail_count   = 0;
        o_pending      = 0;
    end

    // Works out the bytes that one item should leave as, oldest first.
    task automatic predict_code_bytes(input logic cmd, input logic [ID_W-1:0] src,
                                      input logic [ID_W-1:0] tgt, input logic [ID_W-1:0] gap,
                                      input logic [ID_W-1:0] base);
        logic [ID_W-1:0]                  mag;
        logic [MAX_BYTES-1:0][BYTE_W-1:0] codes;
        int                               n;
        t_coded_byte                      entry;
        n     = 0;
        codes = '0;
        if (cmd == CMD_FIRST) begin
            if (tgt >= src) begin
                mag      = tgt - src;
                codes[0] = mag[7:0] & MAG6_MASK;
            end else begin
                mag      = src - tgt;
                codes[0] = (mag[7:0] & MAG6_MASK) | SIGN_BIT;
            end
            mag = mag >> FIRST_BITS;
            if (mag != 0) begin
                codes[0] = codes[0] | CONT_BIT;
            end
            n = 1;
        end else begin
            mag = gap;
        end
        while (mag != 0) begin
            codes[n] = mag[7:0] & GROUP_MASK;
            mag      = mag >> GROUP_BITS;
            if (mag != 0) begin
                codes[n] = codes[n] | CONT_BIT;
            end
            n++;
        end
        for (int k = 0; k < n; k++) begin
            entry.code   = codes[k];
            entry.offset = base + 32'(k);
            entry.last   = (k == n - 1);
            expected_bytes.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_coded_byte want;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected item: byte %02h offset %08h last %0b",
                                 $realtime, i_m_axis_tdata[7:0], i_m_axis_tdata[39:8],
                                 i_m_axis_tlast);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_m_axis_tdata[7:0] !== want.code
                            || i_m_axis_tdata[39:8] !== want.offset
                            || i_m_axis_tlast !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: expected byte %02h offset %08h last %0b, got %02h %08h %0b",
                                     $realtime, want.code, want.offset, want.last,
                                     i_m_axis_tdata[7:0], i_m_axis_tdata[39:8],
                                     i_m_axis_tlast);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_code_bytes(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                   i_s_axis_tdata[63:32], i_s_axis_tdata[95:64],
                                   i_s_axis_tdata[127:96]);
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= mismatch_count;
    end

endmodule

@@ bench/edge_gap_varint_encoder_test.sv @@
`timescale 1ns / 1ps
module edge_gap_varint_encoder_test;
    import egv_pkg::*;

    localparam int RANDOM_ITEMS   = 180;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;   // source_id, target_id, gap, base_offset
    logic         i_s_axis_tuser;   // cmd
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [39:0]  o_m_axis_tdata;   // code_byte, byte_offset
    logic         o_m_axis_tlast;

    int fail_count;
    int pending_bytes;
    int quiet_cycles;
    bit steady;

    edge_gap_varint_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    edge_gap_varint_encoder_check checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending_bytes)
    );

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_FIRST;
        i_m_axis_tready = 1'b0;
        steady          = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Cycles of idling before the next item; none during steady stretches.
    function automatic int draw_pause();
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] span_mask(int bits);
        logic [32:0] one_up;
        one_up = 33'd1 << bits;
        return 32'(one_up - 33'd1);
    endfunction

    task automatic send_item(input logic cmd, input logic [31:0] src, input logic [31:0] tgt,
                             input logic [31:0] gap, input logic [31:0] base);
        int pause;
        pause = draw_pause();
        @(negedge i_clk);
        if (pause > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        i_s_axis_tdata  <= {base, gap, tgt, src};
        i_s_axis_tuser  <= cmd;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Result side: stalls a random number of cycles before each byte, none during steady stretches.
    initial begin : drain
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = draw_pause();
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[edge_gap_varint_encoder] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic        cmd;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] gap;
        logic [31:0] base;
        logic [31:0] diff;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Plain gaps across the group boundaries, zero and the widest values.
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0000_0000, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0000_0001, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0000_007f, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0000_0080, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0000_3fff, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0000_4000, 32'h0000_0000);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h0fff_ffff, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'h1000_0000, $urandom);
        send_item(CMD_PLAIN, $urandom, $urandom, 32'hffff_ffff, 32'hffff_fffe);
        send_item(CMD_PLAIN, 32'h0, 32'h0, 32'h0000_0000, 32'hffff_ffff);

        // First edges: equal ids, either sign, the six-bit boundary and the extremes.
        send_item(CMD_FIRST, 32'h1234_5678, 32'h1234_5678, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0000, 32'h0000_0000, $urandom, 32'hffff_ffff);
        send_item(CMD_FIRST, 32'h0000_0010, 32'h0000_0011, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0011, 32'h0000_0010, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0100, 32'h0000_013f, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0100, 32'h0000_0140, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0140, 32'h0000_0100, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0000, 32'h0000_1fff, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0000, 32'h0000_2000, $urandom, $urandom);
        send_item(CMD_FIRST, 32'h0000_0000, 32'hffff_ffff, $urandom, 32'hffff_fffd);
        send_item(CMD_FIRST, 32'hffff_ffff, 32'h0000_0000, $urandom, $urandom);
        send_item(CMD_FIRST, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = ((i / 30) % 3 == 1);
            cmd    = $urandom_range(0, 1) ? CMD_PLAIN : CMD_FIRST;
            src    = $urandom;
            tgt    = $urandom;
            gap    = $urandom & span_mask($urandom_range(0, 32));
            base   = $urandom;
            // Mostly differences of a chosen size so that every byte count turns up.
            if (cmd == CMD_FIRST && $urandom_range(0, 3) != 0) begin
                diff = $urandom & span_mask($urandom_range(0, 32));
                tgt  = $urandom_range(0, 1) ? src + diff : src - diff;
            end
            if ($urandom_range(0, 7) == 0) begin
                base = 32'hffff_ffff - 32'($urandom_range(0, 4));
            end
            send_item(cmd, src, tgt, gap, base);
        end
        steady = 1'b0;

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[edge_gap_varint_encoder] OK");
        end else begin
            $display("[edge_gap_varint_encoder] ERROR");
        end
        $finish;
    end

endmodule
